>>> sv/dfs_pkg.sv
// Package for the depth-first topological sorter.
// Holds sizes, the node type, and the mark and controller state types.
package dfs_pkg;
  localparam int MaxNodes = 64;
  localparam int MaxEdges = 256;
  localparam int NodeW = 6;
  localparam int EdgeAw = 8;
  localparam int EdgeCntW = 9;
  localparam int CountW = 7;
  localparam int StackAw = 6;

  typedef logic [NodeW-1:0] node_t;

  typedef enum logic [1:0] {
    MARK_WHITE = 2'd0,
    MARK_GRAY  = 2'd1,
    MARK_BLACK = 2'd2
  } mark_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT_RD,
    ST_ROOT_CHK,
    ST_SCAN,
    ST_EDGE,
    ST_MARK,
    ST_POP,
    ST_EMIT,
    ST_CYCLE
  } state_t;
endpackage

>>> sv/dfs_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on dfs_pkg for the field widths.
interface dfs_in_if;
  logic valid;
  logic ready;
  logic action;
  dfs_pkg::node_t dependent_node;
  dfs_pkg::node_t prerequisite_node;
  modport source (output valid, action, dependent_node, prerequisite_node, input ready);
  modport sink (input valid, action, dependent_node, prerequisite_node, output ready);
endinterface

interface dfs_out_if;
  logic valid;
  logic ready;
  dfs_pkg::node_t order_node;
  logic cycle_found;
  logic edge_dropped;
  logic last_result;
  modport source (output valid, order_node, cycle_found, edge_dropped, last_result,
                  input ready);
  modport sink (input valid, order_node, cycle_found, edge_dropped, last_result,
                output ready);
endinterface

>>> sv/dfs_topological_order_top.sv
// Depth-first topological sorter over edge, walk stack, mark and order memories.
// Depends on dfs_pkg and the channel interfaces in dfs_if.sv.
// Throughput: one edge request per cycle while idle. A solve request holds off input while
// it runs: it reads and checks the mark of each root in turn, scans every stored edge from
// each walked node, marks and pushes along each edge leaving it, finishes the node, then
// emits the results in order while the output is ready. Reset: synchronous; clears counters, mark valid bits.
module dfs_topological_order_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [dfs_pkg::CountW-1:0] cfg_wdata,
  dfs_in_if.sink  in_ch,
  dfs_out_if.source out_ch
);
  import dfs_pkg::*;

  logic [CountW-1:0] node_count;
  logic [EdgeCntW-1:0] edge_total;
  logic dropped_flag;
  state_t state, state_next;

  logic [NodeW*2-1:0] edge_mem [MaxEdges];
  logic [NodeW*2-1:0] edge_rd;
  logic [NodeW+EdgeCntW-1:0] stack_mem [MaxNodes];
  logic [NodeW+EdgeCntW-1:0] stack_rd;
  node_t order_mem [MaxNodes];
  node_t order_rd;
  mark_t mark_mem [MaxNodes];
  mark_t mark_rd;
  logic mark_rd_vld;
  logic [MaxNodes-1:0] mark_vld;

  logic [CountW-1:0] stack_height, order_length, emit_idx;
  logic [CountW-1:0] root;
  node_t cur_u;
  logic [EdgeCntW-1:0] cur_pos;

  // Effective node count, saturated to 1 .. MaxNodes.
  logic [CountW-1:0] n_eff;
  always_comb begin
    n_eff = node_count;
    if (node_count == '0) n_eff = CountW'(1);
    if (node_count > CountW'(MaxNodes)) n_eff = CountW'(MaxNodes);
  end

  assign in_ch.ready = (state == ST_IDLE);
  wire in_acc = in_ch.valid && in_ch.ready;
  wire load_ok = !in_ch.action && ({1'b0, in_ch.dependent_node} < n_eff)
                 && ({1'b0, in_ch.prerequisite_node} < n_eff)
                 && (edge_total < EdgeCntW'(MaxEdges));

  node_t ed, ev;
  assign ed = edge_rd[NodeW*2-1:NodeW];
  assign ev = edge_rd[NodeW-1:0];
  wire scan_more = cur_pos < edge_total;
  wire hit = (ed == cur_u) && ({1'b0, ev} < n_eff);
  wire out_take = out_ch.valid && out_ch.ready;
  wire root_ok = root < n_eff;
  wire last_node = (stack_height == CountW'(1));
  wire is_last = (emit_idx + CountW'(1) == order_length);

  // A mark never written in this solve reads as unvisited.
  mark_t mark_cur;
  assign mark_cur = mark_rd_vld ? mark_rd : MARK_WHITE;
  wire push_ok = (mark_cur == MARK_WHITE) && (stack_height < CountW'(MaxNodes));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_acc && in_ch.action) state_next = ST_ROOT_RD;
      ST_ROOT_RD:  state_next = root_ok ? ST_ROOT_CHK : ST_EMIT;
      ST_ROOT_CHK: state_next = (mark_cur == MARK_WHITE) ? ST_SCAN : ST_ROOT_RD;
      ST_SCAN: begin
        if (scan_more) state_next = ST_EDGE;
        else state_next = last_node ? ST_ROOT_RD : ST_POP;
      end
      ST_EDGE:     state_next = hit ? ST_MARK : ST_SCAN;
      ST_MARK: begin
        if (mark_cur == MARK_GRAY) state_next = ST_CYCLE;
        else if (mark_cur == MARK_WHITE && !push_ok) state_next = ST_CYCLE;
        else state_next = ST_SCAN;
      end
      ST_POP:      state_next = ST_SCAN;
      ST_EMIT:     if (out_take && is_last) state_next = ST_IDLE;
      ST_CYCLE:    if (out_take) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Output channel drive.
  always_comb begin
    out_ch.valid = 1'b0;
    out_ch.order_node = order_rd;
    out_ch.cycle_found = 1'b0;
    out_ch.edge_dropped = dropped_flag;
    out_ch.last_result = is_last;
    case (state)
      ST_EMIT: out_ch.valid = 1'b1;
      ST_CYCLE: begin
        out_ch.valid = 1'b1;
        out_ch.order_node = '0;
        out_ch.cycle_found = 1'b1;
        out_ch.last_result = 1'b1;
      end
      default: ;
    endcase
  end

  // Mark memory port select: at most one write per cycle.
  logic mark_we;
  node_t mark_waddr;
  mark_t mark_wdata;
  node_t mark_raddr;
  assign mark_raddr = (state == ST_EDGE) ? ev : root[NodeW-1:0];
  always_comb begin
    mark_we = 1'b0;
    mark_waddr = cur_u;
    mark_wdata = MARK_BLACK;
    case (state)
      ST_ROOT_CHK: begin
        if (mark_cur == MARK_WHITE) begin
          mark_we = 1'b1;
          mark_waddr = root[NodeW-1:0];
          mark_wdata = MARK_GRAY;
        end
      end
      ST_SCAN: if (!scan_more) mark_we = 1'b1;
      ST_MARK: begin
        if (push_ok) begin
          mark_we = 1'b1;
          mark_waddr = ev;
          mark_wdata = MARK_GRAY;
        end
      end
      default: ;
    endcase
  end

  // Mark memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    mark_rd <= mark_mem[mark_raddr];
  end

  // Edge memory: write on load, read at scan position.
  always_ff @(posedge clk) begin
    if (in_acc && load_ok)
      edge_mem[edge_total[EdgeAw-1:0]] <= {in_ch.dependent_node, in_ch.prerequisite_node};
    edge_rd <= edge_mem[cur_pos[EdgeAw-1:0]];
  end

  // The top of the stack lives in cur_u and cur_pos; the memory holds the nodes below it.
  logic [StackAw-1:0] top_idx, below_idx;
  assign top_idx = StackAw'(stack_height - CountW'(1));
  assign below_idx = StackAw'(stack_height - CountW'(2));

  // Stack memory: the parent is saved on a push, and the next entry down is read every
  // cycle so that it is ready in ST_POP after a node finishes.
  always_ff @(posedge clk) begin
    if (state == ST_MARK && push_ok) stack_mem[top_idx] <= {cur_u, cur_pos + EdgeCntW'(1)};
    stack_rd <= stack_mem[below_idx];
  end

  // Order memory: appended on finish, read by the emit index.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && !scan_more) order_mem[order_length[StackAw-1:0]] <= cur_u;
    order_rd <= order_mem[(state == ST_EMIT && out_take) ?
                          StackAw'(emit_idx + CountW'(1)) : emit_idx[StackAw-1:0]];
  end

  // Control registers and the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      node_count <= CountW'(MaxNodes);
      edge_total <= '0;
      dropped_flag <= 1'b0;
      stack_height <= '0;
      order_length <= '0;
      emit_idx <= '0;
      root <= '0;
      cur_pos <= '0;
      cur_u <= '0;
      mark_vld <= '0;
      mark_rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) node_count <= cfg_wdata;
      mark_rd_vld <= mark_vld[mark_raddr];
      if (mark_we) mark_vld[mark_waddr] <= 1'b1;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.action) begin
              root <= '0;
              order_length <= '0;
              emit_idx <= '0;
              stack_height <= '0;
              mark_vld <= '0;
            end else if (load_ok) begin
              edge_total <= edge_total + EdgeCntW'(1);
            end else begin
              dropped_flag <= 1'b1;
            end
          end
        end
        ST_ROOT_CHK: begin
          if (mark_cur == MARK_WHITE) begin
            stack_height <= CountW'(1);
            cur_u <= root[NodeW-1:0];
            cur_pos <= '0;
          end
          root <= root + CountW'(1);
        end
        ST_SCAN: begin
          if (!scan_more) begin
            stack_height <= stack_height - CountW'(1);
            order_length <= order_length + CountW'(1);
          end
        end
        ST_EDGE: if (!hit) cur_pos <= cur_pos + EdgeCntW'(1);
        ST_MARK: begin
          if (push_ok) begin
            stack_height <= stack_height + CountW'(1);
            cur_u <= ev;
            cur_pos <= '0;
          end else begin
            cur_pos <= cur_pos + EdgeCntW'(1);
          end
        end
        ST_POP: begin
          cur_u <= stack_rd[NodeW+EdgeCntW-1:EdgeCntW];
          cur_pos <= stack_rd[EdgeCntW-1:0];
        end
        ST_EMIT: begin
          if (out_take) begin
            emit_idx <= emit_idx + CountW'(1);
            if (is_last) begin
              edge_total <= '0;
              dropped_flag <= 1'b0;
            end
          end
        end
        ST_CYCLE: begin
          if (out_take) begin
            edge_total <= '0;
            dropped_flag <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Stack never exceeds its depth.
  assert property (@(posedge clk) disable iff (rst) stack_height <= CountW'(MaxNodes))
    else $error("stack overflow");
  // Input is held off while a solve is in progress.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("ready during solve");
  // A cycle result always carries the last flag.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.cycle_found) |-> out_ch.last_result)
    else $error("cycle result not last");
endmodule
